@@ src/shdl_pkg.sv @@
// Shared types and constants for the sync header length deframer.
`default_nettype none

package shdl_pkg;

  localparam int ID_WIDTH_DEFAULT = 16;
  localparam int FIELD_W = 16;

  localparam logic [7:0] SYNC_S = 8'h53;
  localparam logic [7:0] SYNC_C = 8'h43;

  localparam logic [FIELD_W-1:0] MAX_BODY_LEN_RESET = 16'hFFFF;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_BODY   = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR  = 2'd1,
    PH_BODY = 2'd2,
    PH_DROP = 2'd3
  } phase_t;

  typedef struct packed {
    logic               kind;
    logic [FIELD_W-1:0] src_id;
    logic [FIELD_W-1:0] tgt_id;
    logic [FIELD_W-1:0] msg_len;
    logic [FIELD_W-1:0] deliver_len;
    logic [7:0]         data_byte;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

@@ src/sync_header_length_deframer_core.sv @@
// Top level of the sync header length deframer: config register, parser and result register.
//
//   channel   direction   transfer when          payload
//   in_       input       in_valid && !in_stall  in_rx_byte
//   out_      output      out_valid && !out_stall kind, ids, lengths, data_byte, last
//   cfg_      input       cfg_wr_en              cfg_wr_data (max_body_len)
//
// One byte is taken every cycle unless the input is stalled; the parser updates its state in the same cycle
// and a result appears in the output register in the cycle after its input transfer.
// Input is stalled only while the output register holds a result that is stalled.
// Reset returns the parser to the sync hunt and sets max_body_len to 65535.
// max_body_len is sampled when a header completes.
`default_nettype none

module sync_header_length_deframer_core #(
  parameter int ID_WIDTH = shdl_pkg::ID_WIDTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_kind,
  output logic [shdl_pkg::FIELD_W-1:0]       out_src_id,
  output logic [shdl_pkg::FIELD_W-1:0]       out_tgt_id,
  output logic [shdl_pkg::FIELD_W-1:0]       out_msg_len,
  output logic [shdl_pkg::FIELD_W-1:0]       out_deliver_len,
  output logic [7:0]                         out_data_byte,
  output logic                               out_last,
  input  wire logic                          cfg_wr_en,
  input  wire logic [shdl_pkg::FIELD_W-1:0]  cfg_wr_data
);

  logic [shdl_pkg::FIELD_W-1:0] max_body_len_r;
  logic                         out_valid_r, out_valid_nxt;
  shdl_pkg::result_t            res_r;
  shdl_pkg::result_t            res;
  logic                         res_valid;
  logic                         in_xfer;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  shdl_parser #(
    .ID_WIDTH (ID_WIDTH)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_xfer),
    .rx_byte      (in_rx_byte),
    .max_body_len (max_body_len_r),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = res_valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_len_r <= shdl_pkg::MAX_BODY_LEN_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_body_len_r <= cfg_wr_data;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = res_r.kind;
  assign out_src_id      = res_r.src_id;
  assign out_tgt_id      = res_r.tgt_id;
  assign out_msg_len     = res_r.msg_len;
  assign out_deliver_len = res_r.deliver_len;
  assign out_data_byte   = res_r.data_byte;
  assign out_last        = res_r.last;

endmodule

`default_nettype wire

@@ src/shdl_parser.sv @@
// Frame parser: sync hunt, header capture, body forwarding and surplus discard.
`default_nettype none

module shdl_parser #(
  parameter int ID_WIDTH = shdl_pkg::ID_WIDTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire logic [7:0]                     rx_byte,
  input  wire logic [shdl_pkg::FIELD_W-1:0]   max_body_len,
  output logic                                res_valid,
  output shdl_pkg::result_t                   res
);

  localparam int ID_BYTES  = (ID_WIDTH + 7) / 8;
  localparam int HDR_BYTES = 2 * ID_BYTES + 2;
  localparam int IDX_W     = $clog2(HDR_BYTES);
  localparam int OUT_W     = (ID_WIDTH < shdl_pkg::FIELD_W) ? ID_WIDTH : shdl_pkg::FIELD_W;
  localparam int HELD_W    = 8 * ID_BYTES;

  shdl_pkg::phase_t phase_r, phase_nxt;
  logic                           saw_s_r, saw_s_nxt;
  logic [IDX_W-1:0]               idx_r, idx_nxt;
  logic [HELD_W-1:0]              src_r, src_nxt;
  logic [HELD_W-1:0]              tgt_r, tgt_nxt;
  logic [shdl_pkg::FIELD_W-1:0]   len_r, len_nxt;
  logic [shdl_pkg::FIELD_W-1:0]   deliver_r, deliver_nxt;
  logic [shdl_pkg::FIELD_W-1:0]   count_r, count_nxt;

  logic                           hdr_done;
  logic [shdl_pkg::FIELD_W-1:0]   len_full;
  logic [shdl_pkg::FIELD_W-1:0]   deliver_calc;
  logic [shdl_pkg::FIELD_W-1:0]   count_inc;
  logic                           body_end;
  logic                           drop_end;
  logic [shdl_pkg::FIELD_W-1:0]   src_out;
  logic [shdl_pkg::FIELD_W-1:0]   tgt_out;

  assign hdr_done     = (idx_r == IDX_W'(HDR_BYTES - 1));
  assign len_full     = {rx_byte, len_r[7:0]};
  assign deliver_calc = (len_full < max_body_len) ? len_full : max_body_len;
  assign count_inc    = count_r + 16'd1;
  assign body_end     = (count_inc >= deliver_r);
  assign drop_end     = (count_inc >= len_r);

  // The ids are masked to the smaller of ID_WIDTH and 16 bits and presented on 16-bit fields.
  always_comb begin
    src_out = '0;
    tgt_out = '0;
    src_out[OUT_W-1:0] = src_r[OUT_W-1:0];
    tgt_out[OUT_W-1:0] = tgt_r[OUT_W-1:0];
  end

  always_comb begin
    phase_nxt = phase_r;
    if (step) begin
      unique case (phase_r)
        shdl_pkg::PH_HUNT: begin
          if (saw_s_r && (rx_byte == shdl_pkg::SYNC_C)) begin
            phase_nxt = shdl_pkg::PH_HDR;
          end
        end
        shdl_pkg::PH_HDR: begin
          if (hdr_done) begin
            if (len_full == '0) begin
              phase_nxt = shdl_pkg::PH_HUNT;
            end else if (deliver_calc == '0) begin
              phase_nxt = shdl_pkg::PH_DROP;
            end else begin
              phase_nxt = shdl_pkg::PH_BODY;
            end
          end
        end
        shdl_pkg::PH_BODY: begin
          if (body_end) begin
            phase_nxt = (len_r > deliver_r) ? shdl_pkg::PH_DROP : shdl_pkg::PH_HUNT;
          end
        end
        shdl_pkg::PH_DROP: begin
          if (drop_end) begin
            phase_nxt = shdl_pkg::PH_HUNT;
          end
        end
        default: phase_nxt = shdl_pkg::PH_HUNT;
      endcase
    end
  end

  always_comb begin
    saw_s_nxt   = saw_s_r;
    idx_nxt     = idx_r;
    src_nxt     = src_r;
    tgt_nxt     = tgt_r;
    len_nxt     = len_r;
    deliver_nxt = deliver_r;
    count_nxt   = count_r;
    if (step) begin
      case (phase_r)
        shdl_pkg::PH_HUNT: begin
          saw_s_nxt = (rx_byte == shdl_pkg::SYNC_S);
          idx_nxt   = '0;
        end
        shdl_pkg::PH_HDR: begin
          for (int j = 0; j < ID_BYTES; j++) begin
            if (idx_r == IDX_W'(j)) begin
              src_nxt[8*j +: 8] = rx_byte;
            end
            if (idx_r == IDX_W'(ID_BYTES + j)) begin
              tgt_nxt[8*j +: 8] = rx_byte;
            end
          end
          if (idx_r == IDX_W'(2 * ID_BYTES)) begin
            len_nxt[7:0] = rx_byte;
          end
          if (hdr_done) begin
            len_nxt     = len_full;
            deliver_nxt = deliver_calc;
            count_nxt   = '0;
            idx_nxt     = '0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        default: begin
          count_nxt = count_inc;
        end
      endcase
    end
  end

  always_comb begin
    res_valid       = 1'b0;
    res.kind        = shdl_pkg::KIND_BODY;
    res.src_id      = src_out;
    res.tgt_id      = tgt_out;
    res.msg_len     = len_r;
    res.deliver_len = deliver_r;
    res.data_byte   = rx_byte;
    res.last        = body_end;
    unique case (phase_r)
      shdl_pkg::PH_HDR: begin
        res_valid       = step && hdr_done;
        res.kind        = shdl_pkg::KIND_HEADER;
        res.msg_len     = len_full;
        res.deliver_len = deliver_calc;
        res.data_byte   = '0;
        res.last        = (deliver_calc == '0);
      end
      shdl_pkg::PH_BODY: begin
        res_valid = step;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= shdl_pkg::PH_HUNT;
      saw_s_r   <= 1'b0;
      idx_r     <= '0;
      len_r     <= '0;
      deliver_r <= '0;
      count_r   <= '0;
    end else begin
      phase_r   <= phase_nxt;
      saw_s_r   <= saw_s_nxt;
      idx_r     <= idx_nxt;
      len_r     <= len_nxt;
      deliver_r <= deliver_nxt;
      count_r   <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;
    tgt_r <= tgt_nxt;
  end

endmodule

`default_nettype wire
